@@ rtl/core/fmrt_pkg.sv @@
// Shared types, constants and slot arithmetic for the first-match route table.
// Used by fmrt_ctrl, fmrt_dpath and first_match_masked_route_table.
`default_nettype none

package fmrt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W     = 7;
   localparam int PORT_W      = 8;
   localparam int ADDR_W      = 32;

   localparam int REQ_DATA_W  = 104;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_INSERT = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [PORT_W-1:0] port;
   } route_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic issue;
      logic scan;
      logic add;
      logic publish;
   } fmrt_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         more;
      logic         rd_valid;
      logic         match;
      logic         out_free;
   } fmrt_sts_type;

   // circular slot index: (base + off) wrapped at the table depth
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(TABLE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/fmrt_ctrl.sv @@
// Controller state machine of the route table: sequences load, add, scan, publish.
// Depends on fmrt_pkg.
`default_nettype none

module fmrt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire fmrt_pkg::fmrt_sts_type sts,
   output fmrt_pkg::fmrt_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.kind)
               fmrt_pkg::REQ_LOOKUP: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               fmrt_pkg::REQ_APPEND, fmrt_pkg::REQ_INSERT: begin
                  cmd.add  = 1'b1;
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan  = 1'b1;
            cmd.issue = sts.more;
            if (sts.match || (!sts.more && !sts.rd_valid)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fmrt_dpath.sv @@
// Datapath of the route table: circular route memory, count, scan compare, result register.
// Depends on fmrt_pkg; driven by fmrt_ctrl.
`default_nettype none

module fmrt_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [fmrt_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire logic [fmrt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [fmrt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire fmrt_pkg::fmrt_cmd_type      cmd,
   output fmrt_pkg::fmrt_sts_type           sts
);

   fmrt_pkg::route_type mem [fmrt_pkg::TABLE_DEPTH];

   fmrt_pkg::req_kind_type            kind_ff;
   logic [fmrt_pkg::ADDR_W-1:0]       addr_ff;
   fmrt_pkg::route_type               new_ff;

   logic [fmrt_pkg::IDX_W-1:0]        head_ff;
   logic [fmrt_pkg::CNT_W-1:0]        count_ff;
   logic [fmrt_pkg::CNT_W-1:0]        scan_ff;
   logic                              rd_valid_ff;
   fmrt_pkg::route_type               rd_data_ff;

   logic                              res_hit_ff;
   logic [fmrt_pkg::PORT_W-1:0]       res_port_ff;
   logic                              res_rej_ff;

   logic                              rsp_valid_ff;
   logic [fmrt_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   logic                              full;
   logic                              match;
   logic [fmrt_pkg::IDX_W-1:0]        rd_slot;
   logic [fmrt_pkg::IDX_W-1:0]        tail_slot;
   logic [fmrt_pkg::IDX_W-1:0]        front_slot;
   logic                              wr_en;
   logic [fmrt_pkg::IDX_W-1:0]        wr_slot;

   assign full       = (count_ff == fmrt_pkg::CNT_W'(fmrt_pkg::TABLE_DEPTH));
   assign match      = rd_valid_ff && ((addr_ff & rd_data_ff.mask) == rd_data_ff.prefix);
   assign rd_slot    = fmrt_pkg::slot_add(head_ff, scan_ff[fmrt_pkg::IDX_W-1:0]);
   assign tail_slot  = fmrt_pkg::slot_add(head_ff, count_ff[fmrt_pkg::IDX_W-1:0]);
   assign front_slot = (head_ff == '0) ? fmrt_pkg::IDX_W'(fmrt_pkg::TABLE_DEPTH - 1)
                                       : head_ff - fmrt_pkg::IDX_W'(1);
   assign wr_en      = cmd.add && !full;
   assign wr_slot    = (kind_ff == fmrt_pkg::REQ_INSERT) ? front_slot : tail_slot;

   assign sts.kind     = kind_ff;
   assign sts.more     = (scan_ff < count_ff);
   assign sts.rd_valid = rd_valid_ff;
   assign sts.match    = match;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // route memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= new_ff;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff       <= fmrt_pkg::req_kind_type'(req_tuser);
         addr_ff       <= req_tdata[31:0];
         new_ff.prefix <= req_tdata[63:32];
         new_ff.mask   <= req_tdata[95:64];
         new_ff.port   <= req_tdata[103:96];
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.issue) begin
         scan_ff <= scan_ff + fmrt_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
         res_port_ff <= '0;
      end else if (cmd.scan && match) begin
         res_port_ff <= rd_data_ff.port;
      end
      if (cmd.publish) begin
         rsp_data_ff <= {{(fmrt_pkg::RSP_DATA_W - 10 - fmrt_pkg::ENTRY_W){1'b0}},
                         fmrt_pkg::ENTRY_W'(count_ff), res_rej_ff, res_port_ff,
                         res_hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         res_hit_ff   <= 1'b0;
         res_rej_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            rd_valid_ff <= cmd.issue;
         end
         if (cmd.load) begin
            res_hit_ff <= 1'b0;
            res_rej_ff <= 1'b0;
         end else begin
            if (cmd.scan && match) begin
               res_hit_ff <= 1'b1;
            end
            if (cmd.add && full) begin
               res_rej_ff <= 1'b1;
            end
         end
         if (wr_en) begin
            count_ff <= count_ff + fmrt_pkg::CNT_W'(1);
            if (kind_ff == fmrt_pkg::REQ_INSERT) begin
               head_ff <= front_slot;
            end
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/first_match_masked_route_table.sv @@
// Top level of the ordered first-match route table: controller plus datapath.
// Depends on fmrt_pkg, fmrt_ctrl and fmrt_dpath.
//
// Usage:
//  - req channel carries one request per transfer: lookup, append at end, or
//    insert at front (req_tuser). Every request gives exactly one rsp transfer.
//  - Routes live in a circular memory; insert moves the head back one slot,
//    so no entries are copied. An add to a full table is refused (rejected=1).
//  - One request is handled at a time. The lookup walks the memory one entry
//    per cycle through its single registered read port and stops at the first
//    match. The next req transfer can come in the cycle in which rsp_tvalid rises.
//  - req_tready is high when no request is in work; the next request is taken
//    while the previous result still waits in the output register.
//  - If rsp_tready is low, the finished result holds and the following result
//    waits in the controller until the output register frees.
//  - Reset (synchronous) empties the table and the output register; memory
//    contents are not cleared and need no clearing pass.
`default_nettype none

module first_match_masked_route_table (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] dest_addr, [63:32] route_prefix, [95:64] route_mask, [103:96] route_port
   input  wire logic [fmrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  wire logic [fmrt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] hit, [8:1] out_port, [9] rejected, [16:10] entry_count, [23:17] zero
   output logic [fmrt_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   fmrt_pkg::fmrt_cmd_type cmd;
   fmrt_pkg::fmrt_sts_type sts;

   fmrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fmrt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire
